>>> src/crmt_pkg.sv
package crmt_pkg;

  localparam int unsigned MAX_RANGES_DEF = 256;
  localparam int unsigned ID_BITS_DEF    = 32;
  localparam int unsigned MODEL_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONCONT = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

endpackage

>>> src/crmt_ram.sv
module crmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/crmt_front.sv
module crmt_front import crmt_pkg::*; #(
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned MODEL_BITS = MODEL_BITS_DEF,
  parameter int unsigned QW         = 2 + MODEL_BITS + 3 * ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [MODEL_BITS-1:0] model_num,
  input  logic [ID_BITS-1:0]    range_start,
  input  logic [ID_BITS-1:0]    range_end,
  input  logic [ID_BITS-1:0]    query_id,
  output logic                  q_valid,
  input  logic                  q_take,
  output logic [QW-1:0]         q_data
);

  // two-entry queue between intake and execution
  logic [QW-1:0] slot [2];
  logic [1:0]    count;
  logic          rd_ptr;
  logic          wr_ptr;
  logic          push;
  logic          pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_data   = slot[rd_ptr];

  // hold items, advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wr_ptr] <= {opcode, model_num, range_start, range_end, query_id};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> in_stall)
    else $error("queue full not flagged");

endmodule

>>> src/crmt_back.sv
module crmt_back import crmt_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned MODEL_BITS = MODEL_BITS_DEF,
  parameter int unsigned QW         = 2 + MODEL_BITS + 3 * ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_take,
  input  logic [QW-1:0]         q_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [MODEL_BITS-1:0] found_model,
  output logic [ID_BITS-1:0]    found_first,
  output logic [ID_BITS-1:0]    found_last,
  output logic                  in_use
);

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = MODEL_BITS + ID_BITS;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
  localparam logic [ID_BITS-1:0] ID_ALL = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_AP_RD, S_AP_CHK, S_LK_RD, S_LK_CHK, S_LK_PREV, S_SC_RD, S_OUT
  } state_t;

  state_t state;

  // latched item
  logic [1:0]            op;
  logic [MODEL_BITS-1:0] mdl;
  logic [ID_BITS-1:0]    lo;
  logic [ID_BITS-1:0]    hi;
  logic [ID_BITS-1:0]    qid;

  logic [CW-1:0]      entry_count;
  logic [ID_BITS-1:0] table_first;
  logic [ID_BITS-1:0] table_last;

  // search / scan indices
  logic [AW-1:0] lo_idx;
  logic [AW-1:0] hi_idx;
  logic [AW-1:0] pos;
  logic [CW-1:0] scan;

  // RAM port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [MODEL_BITS-1:0] rd_model;
  logic [ID_BITS-1:0]    rd_last;
  logic [AW-1:0] mid;
  logic [AW-1:0] last_idx;

  assign rd_model = rd_data[EW-1 -: MODEL_BITS];
  assign rd_last  = rd_data[ID_BITS-1:0];
  assign mid      = lo_idx + ((hi_idx - lo_idx) >> 1);
  assign last_idx = AW'(entry_count - CW'(1));

  crmt_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign q_take = (state == S_IDLE);

  // drive the read address for the next cycle
  always_comb begin
    rd_addr = last_idx;
    case (state)
      S_IDLE:   rd_addr = last_idx;
      S_LK_RD:  rd_addr = mid;
      S_LK_CHK: rd_addr = mid;
      S_LK_PREV: rd_addr = pos - AW'(1);
      S_SC_RD:  rd_addr = scan[AW-1:0];
      default:  rd_addr = last_idx;
    endcase
  end

  // sequence one item at a time
  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
      table_first <= '0;
      table_last  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            {op, mdl, lo, hi, qid} <= q_data;
            status      <= ST_OK;
            found_model <= '0;
            found_first <= '0;
            found_last  <= '0;
            in_use      <= 1'b0;
            lo_idx      <= '0;
            hi_idx      <= last_idx;
            scan        <= '0;
            case (op_t'(q_data[QW-1 -: 2]))
              OP_APPEND: state <= S_AP_RD;
              OP_LOOKUP: state <= S_LK_RD;
              OP_QUERY:  state <= S_SC_RD;
              default: begin
                entry_count <= '0;
                state       <= S_OUT;
              end
            endcase
          end
        end
        S_AP_RD: begin
          // wait for last entry read
          state <= S_AP_CHK;
        end
        S_AP_CHK: begin
          state <= S_OUT;
          if (hi < lo) begin
            status <= ST_NONCONT;
          end else if (entry_count == '0) begin
            wr_en       <= 1'b1;
            wr_addr     <= '0;
            wr_data     <= {mdl, hi};
            entry_count <= CW'(1);
            table_first <= lo;
            table_last  <= hi;
          end else if (table_last == ID_ALL || lo != table_last + ID_BITS'(1)) begin
            status <= ST_NONCONT;
          end else if (rd_model == mdl) begin
            wr_en      <= 1'b1;
            wr_addr    <= last_idx;
            wr_data    <= {mdl, hi};
            table_last <= hi;
          end else if (entry_count >= CNT_MAX) begin
            status <= ST_FULL;
          end else begin
            wr_en       <= 1'b1;
            wr_addr     <= entry_count[AW-1:0];
            wr_data     <= {mdl, hi};
            entry_count <= entry_count + CW'(1);
            table_last  <= hi;
          end
        end
        S_LK_RD: begin
          if (entry_count == '0 || qid < table_first || qid > table_last) begin
            status <= ST_UNKNOWN;
            state  <= S_OUT;
          end else if (lo_idx == hi_idx) begin
            pos   <= lo_idx;
            state <= S_LK_PREV;
          end else begin
            state <= S_LK_CHK;
          end
        end
        S_LK_CHK: begin
          // narrow the interval by the entry read at mid
          if (rd_last < qid) begin
            lo_idx <= mid + AW'(1);
          end else begin
            hi_idx <= mid;
          end
          state <= S_LK_RD;
        end
        S_LK_PREV: begin
          // read of entry pos is not kept; re-read both in two steps
          state <= S_SC_RD;
          scan  <= {1'b1, pos};
        end
        S_SC_RD: begin
          if (scan[CW-1] && op == OP_LOOKUP) begin
            // scan[CW-1] marks lookup finishing: previous entry now, pos next
            found_first <= (pos == '0) ? table_first : rd_last + ID_BITS'(1);
            scan        <= {1'b0, pos};
          end else if (op == OP_LOOKUP) begin
            found_model <= rd_model;
            found_last  <= rd_last;
            state       <= S_OUT;
          end else begin
            // entry scan-1 is on the read port
            if (scan != '0 && rd_model == mdl) begin
              in_use <= 1'b1;
            end
            if (scan >= entry_count) begin
              state <= S_OUT;
            end else begin
              scan <= scan + CW'(1);
            end
          end
        end
        default: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

>>> src/contiguous_range_model_table.sv
// Channel | Signals                                           | Direction
// in      | in_valid, in_stall, opcode..query_id              | into block
// out     | out_valid, out_stall, status..in_use              | out of block
// Back end, one item at a time: append reads the last entry, clear empties the table,
// lookup binary-searches then re-reads the previous and found entry, model query scans
// all entries, via the single memory read port. A stalled result holds the back end.
// A two-entry queue takes items while the back end works.
// Reset (rst, synchronous) empties the table and the queue.
module contiguous_range_model_table import crmt_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
  parameter int unsigned ID_BITS    = ID_BITS_DEF,
  parameter int unsigned MODEL_BITS = MODEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [MODEL_BITS-1:0] model_num,
  input  logic [ID_BITS-1:0]    range_start,
  input  logic [ID_BITS-1:0]    range_end,
  input  logic [ID_BITS-1:0]    query_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [MODEL_BITS-1:0] found_model,
  output logic [ID_BITS-1:0]    found_first,
  output logic [ID_BITS-1:0]    found_last,
  output logic                  in_use
);

  localparam int unsigned QW = 2 + MODEL_BITS + 3 * ID_BITS;

  logic          q_valid;
  logic          q_take;
  logic [QW-1:0] q_data;

  crmt_front #(.ID_BITS(ID_BITS), .MODEL_BITS(MODEL_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .model_num, .range_start,
    .range_end, .query_id, .q_valid, .q_take, .q_data
  );

  crmt_back #(.MAX_RANGES(MAX_RANGES), .ID_BITS(ID_BITS),
              .MODEL_BITS(MODEL_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_data, .out_valid, .out_stall, .status,
    .found_model, .found_first, .found_last, .in_use
  );

endmodule
